### rtl/core/fpts_pkg.sv
`timescale 1ns / 1ps

package fpts_pkg;

   typedef enum logic [1:0] {
      REQ_TICK   = 2'd0,
      REQ_DELAY  = 2'd1,
      REQ_BLOCK  = 2'd2,
      REQ_RESUME = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_READY   = 2'd0,
      ST_BLOCKED = 2'd1,
      ST_DELAYED = 2'd2
   } task_status_type;

   // One request on its way to the scheduler, with the delay already divided.
   typedef struct packed {
      req_kind_type kind;
      logic [2:0]   task_index;
      logic         nonzero;
      logic [31:0]  quotient;
   } fpts_item_type;

endpackage

### rtl/core/fixed_priority_task_scheduler_core.sv
`timescale 1ns / 1ps

// Fixed-priority task scheduler. Each request transfer yields exactly one response
// transfer carrying the running task (lowest ready index, or the idle code NUM_TASKS
// truncated to four bits, as of the last tick or in-range block or nonzero delay) and
// the tick count after the request. It takes one request per cycle unless stalled:
// three pipeline stages divide the delay amount by TICK_DIVISOR with a reciprocal
// multiply, a back multiply and a one-step correction, and the final stage updates
// the task table and registers the response. The enable mask may only be written
// while no request is in flight; a write sets each task to ready or blocked at once.
module fixed_priority_task_scheduler_core
   import fpts_pkg::*;
#(
   parameter int NUM_TASKS    = 8,
   parameter int TICK_DIVISOR = 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_task_enable_mask,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [2:0]  req_task_index,
   input  logic [31:0] req_delay_amount,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_current_task,
   output logic [31:0] rsp_tick_now
);

   logic          div_valid;
   fpts_item_type div_item;
   logic          sched_ready;

   fpts_div #(
      .TICK_DIVISOR(TICK_DIVISOR)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_task_index(req_task_index),
      .req_delay_amount(req_delay_amount),
      .item_valid(div_valid),
      .item(div_item),
      .item_ready(sched_ready)
   );

   fpts_sched #(
      .NUM_TASKS(NUM_TASKS)
   ) u_sched (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_task_enable_mask(csr_task_enable_mask),
      .item_valid(div_valid),
      .item(div_item),
      .item_ready(sched_ready),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_current_task(rsp_current_task),
      .rsp_tick_now(rsp_tick_now)
   );

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      (div_valid && sched_ready) |=> rsp_valid)
      else $error("scheduler took an item without raising a response");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((NUM_TASKS >= 16) || (int'(rsp_current_task) <= NUM_TASKS)))
      else $error("running task beyond the idle code");

   assert property (@(posedge clock) disable iff (reset)
      ((rsp_valid && !rsp_stall) ##1 rsp_valid) |->
      ((rsp_tick_now - $past(rsp_tick_now)) <= 32'd1))
      else $error("tick advanced by more than one between responses");

endmodule

### rtl/core/fpts_div.sv
`timescale 1ns / 1ps

module fpts_div
   import fpts_pkg::*;
#(
   parameter int TICK_DIVISOR = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_type,
   input  logic [2:0]    req_task_index,
   input  logic [31:0]   req_delay_amount,
   output logic          item_valid,
   output fpts_item_type item,
   input  logic          item_ready
);

   localparam int DIV_LOG = $clog2(TICK_DIVISOR);
   localparam bit IS_POW2 = ((1 << DIV_LOG) == TICK_DIVISOR);
   localparam int RECIP_SHIFT = IS_POW2 ? DIV_LOG : DIV_LOG - 1;
   localparam logic [63:0] RECIP_FULL = (64'd1 << (32 + RECIP_SHIFT)) / 64'(TICK_DIVISOR);
   localparam logic [31:0] RECIP = RECIP_FULL[31:0];
   localparam logic [31:0] DIV_VALUE = 32'(TICK_DIVISOR);

   logic          s1_valid_ff, s1_valid_in;
   fpts_item_type s1_item_ff, s1_item_in;
   logic [31:0]   s1_amount_ff;
   logic          s2_valid_ff, s2_valid_in;
   fpts_item_type s2_item_ff;
   logic [31:0]   s2_amount_ff;
   logic [31:0]   s2_back_ff, s2_back_in;
   logic          s3_valid_ff, s3_valid_in;
   fpts_item_type s3_item_ff, s3_item_in;

   logic          s1_ready, s2_ready, s3_ready;
   logic [63:0]   product;
   logic [31:0]   remainder;

   assign s3_ready = !s3_valid_ff || item_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   assign s1_valid_in = req_valid;
   assign s2_valid_in = s1_valid_ff;
   assign s3_valid_in = s2_valid_ff;

   // The reciprocal estimate is at most one below the true quotient.
   assign product = 64'(req_delay_amount) * 64'(RECIP);

   always_comb begin
      s1_item_in.kind       = req_kind_type'(req_type);
      s1_item_in.task_index = req_task_index;
      s1_item_in.nonzero    = (req_delay_amount != 32'd0);
      if (IS_POW2) begin
         s1_item_in.quotient = req_delay_amount >> DIV_LOG;
      end else begin
         s1_item_in.quotient = 32'(product >> (32 + RECIP_SHIFT));
      end
   end

   assign s2_back_in = s1_item_ff.quotient * DIV_VALUE;
   assign remainder = s2_amount_ff - s2_back_ff;

   always_comb begin
      s3_item_in = s2_item_ff;
      if (remainder >= DIV_VALUE) begin
         s3_item_in.quotient = s2_item_ff.quotient + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (s2_ready) begin
            s2_valid_ff <= s2_valid_in;
         end
         if (s3_ready) begin
            s3_valid_ff <= s3_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_item_ff   <= s1_item_in;
         s1_amount_ff <= req_delay_amount;
      end
      if (s2_ready) begin
         s2_item_ff   <= s1_item_ff;
         s2_amount_ff <= s1_amount_ff;
         s2_back_ff   <= s2_back_in;
      end
      if (s3_ready) begin
         s3_item_ff <= s3_item_in;
      end
   end

   assign item_valid = s3_valid_ff;
   assign item = s3_item_ff;

endmodule

### rtl/core/fpts_sched.sv
`timescale 1ns / 1ps

module fpts_sched
   import fpts_pkg::*;
#(
   parameter int NUM_TASKS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [7:0]    csr_task_enable_mask,
   input  logic          item_valid,
   input  fpts_item_type item,
   output logic          item_ready,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [3:0]    rsp_current_task,
   output logic [31:0]   rsp_tick_now
);

   localparam int PICK_W = $clog2(NUM_TASKS + 1);
   localparam logic [7:0] MASK_RESET = 8'hFF;

   task_status_type status_ff [NUM_TASKS];
   task_status_type status_in [NUM_TASKS];
   logic [31:0]     wake_ff [NUM_TASKS];
   logic [31:0]     wake_in [NUM_TASKS];
   logic [31:0]     tick_ff, tick_in;
   logic [3:0]      running_ff, running_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic              hit;
   logic              in_range;
   logic              run_pass;
   logic              target;
   logic              woke;
   logic [31:0]       wake_new;
   logic [PICK_W-1:0] pick;

   function automatic task_status_type mask_status(logic [7:0] mask, int slot);
      task_status_type result;
      result = ST_BLOCKED;
      if (slot < 8) begin
         if (mask[slot[2:0]]) begin
            result = ST_READY;
         end
      end
      return result;
   endfunction

   assign item_ready = !rsp_valid_ff || !rsp_stall;
   assign hit = item_valid && item_ready;
   assign wake_new = tick_ff + item.quotient;

   always_comb begin
      in_range = (int'(item.task_index) < NUM_TASKS);
      run_pass = (item.kind == REQ_TICK) ||
                 (in_range && (((item.kind == REQ_DELAY) && item.nonzero) ||
                               (item.kind == REQ_BLOCK)));
      target = 1'b0;
      woke = 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
         status_in[i] = status_ff[i];
         wake_in[i] = wake_ff[i];
         woke = (status_ff[i] == ST_DELAYED) && (wake_ff[i] == tick_ff);
         target = in_range && (item.kind != REQ_TICK) && (int'(item.task_index) == i);
         if (target) begin
            case (item.kind)
               REQ_DELAY: begin
                  if (item.nonzero) begin
                     status_in[i] = ST_DELAYED;
                     wake_in[i] = wake_new;
                     woke = (item.quotient == 32'd0);
                  end
               end
               REQ_BLOCK: begin
                  status_in[i] = ST_BLOCKED;
                  woke = 1'b0;
               end
               REQ_RESUME: begin
                  status_in[i] = ST_READY;
               end
               default: begin
                  status_in[i] = status_ff[i];
               end
            endcase
         end
         if (run_pass && woke) begin
            status_in[i] = ST_READY;
         end
      end

      // Lowest index wins; the idle code stands when nothing is ready.
      pick = PICK_W'(NUM_TASKS);
      for (int i = NUM_TASKS - 1; i >= 0; i--) begin
         if (status_in[i] == ST_READY) begin
            pick = PICK_W'(i);
         end
      end

      tick_in = run_pass ? tick_ff + 32'd1 : tick_ff;
      running_in = run_pass ? 4'(pick) : running_ff;
   end

   always_comb begin
      if (hit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            status_ff[i] <= mask_status(MASK_RESET, i);
         end
         tick_ff      <= 32'd0;
         running_ff   <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
               status_ff[i] <= mask_status(csr_task_enable_mask, i);
            end
         end else if (hit) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
               status_ff[i] <= status_in[i];
            end
         end
         if (hit) begin
            tick_ff    <= tick_in;
            running_ff <= running_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            wake_ff[i] <= wake_in[i];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_current_task = running_ff;
   assign rsp_tick_now = tick_ff;

endmodule
